// ===== rtl/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rfa_pkg: shared definitions for the reference-counted frame allocator
// Default geometry, operation and status codes, and the bit search result type.
// ----------------------------------------------------------------------------
`default_nettype none
package rfa_pkg;
	localparam int RFA_TOTAL_FRAMES = 8192;
	localparam int RFA_MAP_WORDS    = 256;
	localparam int RFA_PAGE_SHIFT   = 12;

	localparam logic [2:0] OP_ALLOC     = 3'd0;
	localparam logic [2:0] OP_FREE      = 3'd1;
	localparam logic [2:0] OP_REF       = 3'd2;
	localparam logic [2:0] OP_UNREF     = 3'd3;
	localparam logic [2:0] OP_GET       = 3'd4;
	localparam logic [2:0] OP_MARK_USED = 3'd5;
	localparam logic [2:0] OP_MARK_FREE = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic       found;
		logic [4:0] idx;
	} ffz_res_t;
endpackage
`default_nettype wire

// ===== rtl/rfa_ffz.sv =====
// ----------------------------------------------------------------------------
// rfa_ffz: find first zero
// Returns the position of the lowest clear bit of one 32-bit map word.
// ----------------------------------------------------------------------------
`default_nettype none
module rfa_ffz (
	input  wire logic [31:0]      word,
	output rfa_pkg::ffz_res_t     res
);
	import rfa_pkg::*;

	always_comb begin
		res = '0;
		// Walk from the top so that the lowest clear bit is the one left.
		for (int i = 31; i >= 0; i--) begin
			if (!word[i]) begin
				res.found = 1'b1;
				res.idx   = 5'(i);
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/refcounted_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_frame_allocator: bitmap page-frame allocator with reference counts
// Keeps a used-bit map, a 16-bit count per frame and a running free total.
// ----------------------------------------------------------------------------
// After reset a sweep over max(TOTAL_FRAMES, MAP_WORDS) addresses sets every map
// word to all ones and every count to zero; no transaction is taken meanwhile.
// Free, ref, unref and get step through read, read-modify-write and result load
// before the next acceptance; an out-of-range frame or bad op skips the middle step.
// Alloc reads and checks one map word at a time; mark ranges read and write one
// frame at a time. A stalled result holds off the next acceptance. Free total resets to 0.
`default_nettype none
module refcounted_frame_allocator #(
	parameter int TOTAL_FRAMES = rfa_pkg::RFA_TOTAL_FRAMES,
	parameter int MAP_WORDS    = rfa_pkg::RFA_MAP_WORDS,
	parameter int PAGE_SHIFT   = rfa_pkg::RFA_PAGE_SHIFT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] addr,
	input  wire logic [31:0] len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      frame_addr,
	output logic [15:0]      ref_count,
	output logic [13:0]      free_count,
	output logic [1:0]       status
);
	import rfa_pkg::*;

	// Only frames below this limit exist; map bits above it stay set forever.
	localparam int FRAME_LIMIT = (TOTAL_FRAMES < MAP_WORDS * 32) ? TOTAL_FRAMES
	                                                              : MAP_WORDS * 32;
	localparam int CLR_N = (TOTAL_FRAMES > MAP_WORDS) ? TOTAL_FRAMES : MAP_WORDS;
	localparam int CW    = $clog2(CLR_N);
	localparam int RW    = $clog2(TOTAL_FRAMES);
	localparam int MW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int FW    = 32 - PAGE_SHIFT;
	localparam int FCW   = $clog2(FRAME_LIMIT + 1);
	localparam logic [31:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

	// Sequencer states.
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_RMW   = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_SCHK  = 4'd5;
	localparam logic [3:0] S_MLOOP = 4'd6;
	localparam logic [3:0] S_MWR   = 4'd7;
	localparam logic [3:0] S_PUT   = 4'd8;

	logic [3:0]      state_q;
	logic [CW-1:0]   clr_q;
	logic [2:0]      op_q;
	logic [31:0]     addr_q;
	logic [31:0]     len_q;
	logic [MW-1:0]   w_q;
	logic [FW-1:0]   f_q;
	logic [FW-1:0]   end_q;
	logic [FCW-1:0]  free_q;

	logic [31:0]     res_faddr_q;
	logic [15:0]     res_cnt_q;
	logic [1:0]      res_status_q;
	logic            out_valid_q;
	logic [31:0]     out_faddr_q;
	logic [15:0]     out_cnt_q;
	logic [13:0]     out_free_q;
	logic [1:0]      out_status_q;

	// The two memories, each with one write port and one registered read port.
	logic [31:0]     map_mem [MAP_WORDS];
	logic [15:0]     ref_mem [TOTAL_FRAMES];
	logic [31:0]     map_rd_q;
	logic [15:0]     ref_rd_q;
	logic [MW-1:0]   map_raddr;
	logic            map_we;
	logic [MW-1:0]   map_waddr;
	logic [31:0]     map_wdata;
	logic            ref_we;
	logic [RW-1:0]   ref_waddr;
	logic [15:0]     ref_wdata;

	// Operand decode.
	logic [FW-1:0]   frame;
	logic [31:0]     frame32;
	logic            in_range;
	logic [31:0]     f32;
	logic [31:0]     range_sum;
	logic [FW-1:0]   range_end;
	logic [FW-1:0]   range_endc;

	// Arithmetic results of the current step.
	ffz_res_t        ffz;
	logic [31:0]     alloc_f;
	logic            rmw_bit;
	logic [15:0]     rmw_cnt;
	logic            rmw_clear;
	logic            mk_bit;
	logic            free_inc;
	logic            free_dec;
	logic            out_free_slot;
	logic [31:0]     free_wide;

	assign frame     = addr_q[31:PAGE_SHIFT];
	assign frame32   = 32'(frame);
	assign in_range  = frame32 < 32'(FRAME_LIMIT);
	assign f32       = 32'(f_q);
	assign range_sum = addr_q + len_q + PAGE_MASK;
	assign range_end = range_sum[31:PAGE_SHIFT];
	assign range_endc = (32'(range_end) > 32'(FRAME_LIMIT)) ? FW'(FRAME_LIMIT)
	                                                          : range_end;
	assign alloc_f   = {(32 - MW - 5)'(0), w_q, ffz.idx};
	assign rmw_bit   = map_rd_q[frame32[4:0]];
	assign mk_bit    = map_rd_q[f32[4:0]];
	assign out_free_slot = !out_valid_q || !out_stall;
	assign free_wide = 32'(free_q);

	rfa_ffz u_ffz (
		.word (map_rd_q),
		.res  (ffz)
	);

	// New count of a single-frame operation and whether its map bit clears.
	always_comb begin
		rmw_cnt   = ref_rd_q;
		rmw_clear = 1'b0;
		case (op_q)
			OP_FREE: begin
				rmw_cnt   = '0;
				rmw_clear = rmw_bit;
			end
			OP_REF: begin
				rmw_cnt = (ref_rd_q == COUNT_MAX) ? ref_rd_q : ref_rd_q + 16'd1;
			end
			OP_UNREF: begin
				if (ref_rd_q != '0) begin
					rmw_cnt   = ref_rd_q - 16'd1;
					rmw_clear = (ref_rd_q == 16'd1) && rmw_bit;
				end
			end
			default: begin
				rmw_cnt = ref_rd_q;
			end
		endcase
	end

	// Memory port control.
	always_comb begin
		map_raddr = frame32[MW+4:5];
		map_we    = 1'b0;
		map_waddr = frame32[MW+4:5];
		map_wdata = map_rd_q;
		ref_we    = 1'b0;
		ref_waddr = frame32[RW-1:0];
		ref_wdata = rmw_cnt;
		free_inc  = 1'b0;
		free_dec  = 1'b0;
		case (state_q)
			S_CLR: begin
				map_we    = 32'(clr_q) < 32'(MAP_WORDS);
				map_waddr = clr_q[MW-1:0];
				map_wdata = WORD_ONES;
				ref_we    = 32'(clr_q) < 32'(TOTAL_FRAMES);
				ref_waddr = clr_q[RW-1:0];
				ref_wdata = '0;
			end
			S_SCAN: begin
				map_raddr = w_q;
			end
			S_MLOOP: begin
				map_raddr = f32[MW+4:5];
			end
			S_RMW: begin
				ref_we    = (op_q == OP_FREE) || (op_q == OP_REF) || (op_q == OP_UNREF);
				map_we    = rmw_clear;
				map_wdata = map_rd_q & ~(32'd1 << frame32[4:0]);
				free_inc  = rmw_clear;
			end
			S_SCHK: begin
				if (ffz.found) begin
					map_we    = 1'b1;
					map_waddr = w_q;
					map_wdata = map_rd_q | (32'd1 << ffz.idx);
					ref_we    = 1'b1;
					ref_waddr = alloc_f[RW-1:0];
					ref_wdata = 16'd1;
					free_dec  = 1'b1;
				end
			end
			S_MWR: begin
				map_waddr = f32[MW+4:5];
				if (op_q == OP_MARK_USED) begin
					map_we    = !mk_bit;
					map_wdata = map_rd_q | (32'd1 << f32[4:0]);
					free_dec  = !mk_bit;
				end else begin
					map_we    = mk_bit;
					map_wdata = map_rd_q & ~(32'd1 << f32[4:0]);
					free_inc  = mk_bit;
				end
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_q <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_waddr] <= ref_wdata;
		end
		ref_rd_q <= ref_mem[frame32[RW-1:0]];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_inc) begin
				free_q <= free_q + FCW'(1);
			end else if (free_dec) begin
				free_q <= free_q - FCW'(1);
			end
			// In S_PUT a free slot is refilled below, so the clear is left out there.
			if (out_valid_q && !out_stall && state_q != S_PUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						addr_q  <= addr;
						len_q   <= len;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_faddr_q  <= '0;
					res_cnt_q    <= '0;
					w_q          <= '0;
					f_q          <= frame;
					end_q        <= range_endc;
					case (op_q)
						OP_ALLOC: begin
							res_status_q <= ST_OK;
							state_q      <= S_SCAN;
						end
						OP_FREE, OP_REF, OP_UNREF, OP_GET: begin
							if (in_range) begin
								res_status_q <= ST_OK;
								state_q      <= S_RMW;
							end else begin
								res_status_q <= ST_IGNORED;
								state_q      <= S_PUT;
							end
						end
						OP_MARK_USED, OP_MARK_FREE: begin
							res_status_q <= ST_OK;
							state_q      <= S_MLOOP;
						end
						default: begin
							res_status_q <= ST_IGNORED;
							state_q      <= S_PUT;
						end
					endcase
				end
				S_RMW: begin
					res_cnt_q <= (op_q == OP_FREE) ? 16'd0 : rmw_cnt;
					state_q   <= S_PUT;
				end
				S_SCAN: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (ffz.found) begin
						res_faddr_q <= alloc_f << PAGE_SHIFT;
						res_cnt_q   <= 16'd1;
						state_q     <= S_PUT;
					end else if (32'(w_q) == 32'(MAP_WORDS - 1)) begin
						res_status_q <= ST_NOSPACE;
						state_q      <= S_PUT;
					end else begin
						w_q     <= w_q + MW'(1);
						state_q <= S_SCAN;
					end
				end
				S_MLOOP: begin
					state_q <= (f_q < end_q) ? S_MWR : S_PUT;
				end
				S_MWR: begin
					f_q     <= f_q + FW'(1);
					state_q <= S_MLOOP;
				end
				S_PUT: begin
					if (out_free_slot) begin
						out_valid_q  <= 1'b1;
						out_faddr_q  <= res_faddr_q;
						out_cnt_q    <= res_cnt_q;
						out_free_q   <= free_wide[13:0];
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign frame_addr = out_faddr_q;
	assign ref_count  = out_cnt_q;
	assign free_count = out_free_q;
	assign status     = out_status_q;

	// The free total can never exceed the number of existing frames.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_q) <= 32'(FRAME_LIMIT))
		else $error("free total above frame count");

	// An accepted transaction always starts the sequencer.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISP))
		else $error("accepted transaction did not start");

	// A failed allocation reports no frame and no count.
	a_nospace_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NOSPACE) |-> (frame_addr == '0 && ref_count == '0))
		else $error("no-space result carries data");

	// The free total only moves while an operation is in progress.
	a_free_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_PUT) |=> $stable(free_q))
		else $error("free total changed while idle");
endmodule
`default_nettype wire

// ===== bench/frame_alloc_checker.sv =====
// ----------------------------------------------------------------------------
// frame_alloc_checker: result checker for the frame allocator
// Watches both channels, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module frame_alloc_checker
	import rfa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] addr,
	input  wire logic [31:0] len,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [31:0] frame_addr,
	input  wire logic [15:0] ref_count,
	input  wire logic [13:0] free_count,
	input  wire logic [1:0]  status,
	output int               fail_count,
	output int               pending,
	output int               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = (RFA_TOTAL_FRAMES < RFA_MAP_WORDS * 32) ?
		RFA_TOTAL_FRAMES : RFA_MAP_WORDS * 32;

	typedef struct packed {
		logic [31:0] faddr;
		logic [15:0] cnt;
		logic [13:0] nfree;
		logic [1:0]  st;
	} alloc_result_t;

	logic [31:0]   map_words [RFA_MAP_WORDS];
	logic [15:0]   counts [RFA_TOTAL_FRAMES];
	int unsigned   free_frames;
	alloc_result_t expected_q[$];

	function automatic void set_used(int unsigned f);
		if (!map_words[f / 32][f % 32]) begin
			map_words[f / 32][f % 32] = 1'b1;
			free_frames--;
		end
	endfunction

	function automatic void set_free(int unsigned f);
		if (map_words[f / 32][f % 32]) begin
			map_words[f / 32][f % 32] = 1'b0;
			free_frames++;
		end
	endfunction

	function automatic alloc_result_t predict_op(logic [2:0] o, logic [31:0] a,
			logic [31:0] l);
		alloc_result_t r;
		int unsigned   frame;
		logic [31:0]   end_addr;
		int unsigned   stop;
		bit            in_map;
		r = '0;
		frame = a >> RFA_PAGE_SHIFT;
		in_map = frame < LIMIT;
		case (o)
			OP_ALLOC: begin
				r.st = ST_NOSPACE;
				for (int f = 0; f < LIMIT; f++) begin
					if (!map_words[f / 32][f % 32]) begin
						set_used(f);
						counts[f] = 16'd1;
						r.cnt = 16'd1;
						r.faddr = 32'(f << RFA_PAGE_SHIFT);
						r.st = ST_OK;
						break;
					end
				end
			end
			OP_FREE, OP_REF, OP_UNREF, OP_GET: begin
				if (!in_map) begin
					r.st = ST_IGNORED;
				end else begin
					if (o == OP_FREE) begin
						counts[frame] = '0;
						set_free(frame);
					end else if (o == OP_REF) begin
						if (counts[frame] != COUNT_MAX)
							counts[frame]++;
					end else if (o == OP_UNREF && counts[frame] != 0) begin
						counts[frame]--;
						if (counts[frame] == 0)
							set_free(frame);
					end
					r.cnt = (o == OP_FREE) ? 16'd0 : counts[frame];
				end
			end
			OP_MARK_USED, OP_MARK_FREE: begin
				end_addr = a + l + 32'((1 << RFA_PAGE_SHIFT) - 1);
				stop = end_addr >> RFA_PAGE_SHIFT;
				if (stop > LIMIT)
					stop = LIMIT;
				for (int unsigned f = frame; f < stop; f++) begin
					if (o == OP_MARK_USED)
						set_used(f);
					else
						set_free(f);
				end
			end
			default: r.st = ST_IGNORED;
		endcase
		r.nfree = 14'(free_frames);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		alloc_result_t got;
		if (!arst_n) begin
			foreach (map_words[i])
				map_words[i] = '1;
			foreach (counts[i])
				counts[i] = '0;
			free_frames = 0;
			expected_q.delete();
			fail_count <= 0;
			checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{frame_addr, ref_count, free_count, status};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					checked <= checked + 1;
					if (e.faddr !== got.faddr || e.cnt !== got.cnt ||
							e.nfree !== got.nfree || e.st !== got.st) begin
						$display("%0t: mismatch expected addr=%h cnt=%0d free=%0d st=%0d",
							$time, e.faddr, e.cnt, e.nfree, e.st);
						$display("%0t:          actual   addr=%h cnt=%0d free=%0d st=%0d",
							$time, got.faddr, got.cnt, got.nfree, got.st);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_op(op, addr, len));
		end
		pending <= expected_q.size();
	end
endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the frame allocator
// Drives directed and random allocator transactions with random idling.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rfa_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = OP_GET;
	logic [31:0] addr = '0;
	logic [31:0] len = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] frame_addr;
	logic [15:0] ref_count;
	logic [13:0] free_count;
	logic [1:0]  status;
	int          fail_count;
	int          pending;
	int          checked;
	bit          quiet = 1'b0;	// no idling in the final stretch
	int          sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	refcounted_frame_allocator dut (.*);

	frame_alloc_checker checker_i (.*);

	// The receiver stalls in random bursts, alternating with free stretches.
	initial begin
		int n;
		forever begin
			n = $urandom_range(1, 13);
			repeat (n) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// Offer one transaction and hold it until the block takes it. Valid stays
	// high between back-to-back transactions and drops only for idling.
	task automatic send_op(logic [2:0] o, logic [31:0] a, logic [31:0] l);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		addr <= a;
		len <= l;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Most addresses land in a small window of low frames so that allocation,
	// reference counting and range marks keep interacting.
	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		a = $urandom;
		case ($urandom_range(0, 9))
			0: return a;	// anywhere, usually out of range
			1: return {19'd0, a[12:0]} << 12 | {20'd0, a[31:20]};
			default: return (32'($urandom_range(0, 63)) << 12) | (a & 32'hFFF);
		endcase
	endfunction

	function automatic logic [31:0] pick_len();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 8192);
			default: return 32'($urandom_range(0, 6 * 4096));
		endcase
	endfunction

	initial begin
		int pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: alloc on a full map, then open a window and work on it.
		send_op(OP_ALLOC, 32'd0, 32'd0);
		send_op(OP_MARK_FREE, 32'd0, 32'h0000_8000);
		send_op(OP_ALLOC, 32'd0, 32'd0);	// frame zero answers address 0
		send_op(OP_ALLOC, 32'd0, 32'd0);
		send_op(OP_REF, 32'h0000_1FFF, 32'd0);
		send_op(OP_GET, 32'h0000_1000, 32'd0);
		send_op(OP_UNREF, 32'h0000_1000, 32'd0);
		send_op(OP_UNREF, 32'h0000_1000, 32'd0);
		send_op(OP_UNREF, 32'h0000_1000, 32'd0);	// count already zero
		send_op(OP_FREE, 32'd0, 32'd0);
		send_op(OP_GET, 32'hFFFF_FFFF, 32'd0);	// beyond the last frame
		send_op(OP_REF, 32'h01FF_F000, 32'd0);	// last existing frame
		send_op(OP_FREE, 32'h0200_0000, 32'd0);
		send_op(OP_UNREF, 32'hFFFF_F000, 32'd0);
		send_op(3'd7, 32'h1234_5678, 32'hFFFF_FFFF);
		send_op(OP_MARK_USED, 32'h0000_4000, 32'h0000_0001);
		send_op(OP_MARK_USED, 32'h0000_2000, 32'd0);	// empty range
		send_op(OP_MARK_FREE, 32'h01FF_E000, 32'hFFFF_FFFF);	// end wraps
		send_op(OP_MARK_FREE, 32'h01FF_E000, 32'h0001_0000);	// clipped at the top
		send_op(OP_MARK_USED, 32'h01FF_E000, 32'h0000_2000);
		// An alloc takes the lowest free frame; then free frame 2 picks up three references.
		send_op(OP_ALLOC, 32'd0, 32'd0);
		for (int i = 0; i < 3; i++)
			send_op(OP_REF, 32'h0000_2000, 32'd0);
		// The full map sweep only needs a handful of large marks; rest is random.
		for (int i = 0; i < 1500; i++) begin
			if (i > 1350)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 25)
				send_op(OP_ALLOC, $urandom, $urandom);
			else if (pick < 37)
				send_op(OP_FREE, pick_addr(), $urandom);
			else if (pick < 55)
				send_op(OP_REF, pick_addr(), $urandom);
			else if (pick < 70)
				send_op(OP_UNREF, pick_addr(), $urandom);
			else if (pick < 80)
				send_op(OP_GET, pick_addr(), $urandom);
			else if (pick < 89)
				send_op(OP_MARK_USED, pick_addr(), pick_len());
			else if (pick < 98)
				send_op(OP_MARK_FREE, pick_addr(), pick_len());
			else
				send_op(3'd7, $urandom, $urandom);
		end
		in_valid <= 1'b0;
		// Drain, then allow a short tail for any stray result.
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d allocator transactions, %0d results compared.", sent, checked);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// A mark over the whole map walks every frame; leave ample margin.
	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end
endmodule
